// ----- rtl/core/cfdp_pkg.sv -----
// Shared types and constants for the command frame decimal parser.
// Holds the header table, command codes and the event record passed front to back.
package cfdp_pkg;

  localparam int HDR_LEN   = 5;
  localparam int NUM_HDR   = 10;
  localparam int HDR_POS_W = 3;
  localparam int CMD_W     = 4;
  localparam int SLOT_W    = 5;
  localparam int VALUE_W   = 32;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  localparam logic [SLOT_W-1:0] SLOT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_TEST      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_READ_ALL  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE_1   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE_2   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE_3   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 4'd5;
  localparam logic [CMD_W-1:0] CMD_READ_1    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_READ_2    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_READ_3    = 4'd8;
  localparam logic [CMD_W-1:0] CMD_WRITE_ALL = 4'd9;

  localparam logic KIND_FIELD   = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_CLOSE   = 8'h7D;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // One entry per decoded byte that produces output.
  typedef struct packed {
    logic                      has_field;
    logic                      has_cmd;
    logic [CMD_W-1:0]          command;
    logic [SLOT_W-1:0]         slot;
    logic [VALUE_W-1:0]        value;
    logic                      slot_overflow;
  } event_t;

  function automatic logic [7:0] hdr_byte(input logic [CMD_W-1:0] idx,
                                          input logic [HDR_POS_W-1:0] pos);
    logic [39:0] row;
    case (idx)
      4'd0:    row = "{Tes}";
      4'd1:    row = "{RDA}";
      4'd2:    row = "{WR1:";
      4'd3:    row = "{WR2:";
      4'd4:    row = "{WR3:";
      4'd5:    row = "{RD0}";
      4'd6:    row = "{RD1}";
      4'd7:    row = "{RD2}";
      4'd8:    row = "{RD3}";
      4'd9:    row = "{WRA:";
      default: row = '0;
    endcase
    case (pos)
      3'd0:    hdr_byte = row[39:32];
      3'd1:    hdr_byte = row[31:24];
      3'd2:    hdr_byte = row[23:16];
      3'd3:    hdr_byte = row[15:8];
      3'd4:    hdr_byte = row[7:0];
      default: hdr_byte = 8'h00;
    endcase
  endfunction

  function automatic logic is_write(input logic [CMD_W-1:0] cmd);
    is_write = (cmd == CMD_WRITE_1) || (cmd == CMD_WRITE_2) ||
               (cmd == CMD_WRITE_3) || (cmd == CMD_WRITE_ALL);
  endfunction

endpackage

// ----- rtl/core/cfdp_front.sv -----
// Front end: header match, field accumulation and slot counting, one byte a cycle while take is high.
// Depends on cfdp_pkg; emits event_t records to the queue.
module cfdp_front #(
  parameter int WRITE_SLOTS     = 10,
  parameter int WRITE_ALL_SLOTS = 30,
  parameter int MAX_FIELD_CHARS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      ch,
  output logic            push,
  output cfdp_pkg::event_t ev
);
  import cfdp_pkg::*;

  localparam int FC_W = $clog2(MAX_FIELD_CHARS + 1);
  localparam logic [FC_W-1:0]   FC_MAX    = FC_W'(MAX_FIELD_CHARS);
  localparam logic [SLOT_W-1:0] LIM_WRITE = SLOT_W'(WRITE_SLOTS);
  localparam logic [SLOT_W-1:0] LIM_ALL   = SLOT_W'(WRITE_ALL_SLOTS);

  logic [HDR_POS_W-1:0] header_pos;
  logic [NUM_HDR-1:0]   candidate_mask;
  logic [CMD_W-1:0]     matched_command;
  logic                 in_body;
  logic                 frame_done;
  logic [FC_W-1:0]      field_chars;
  logic [VALUE_W-1:0]   accumulator;
  logic                 negative;
  logic                 digits_stopped;
  logic [SLOT_W-1:0]    slot_count;

  logic [NUM_HDR-1:0]   mask_next;
  logic [CMD_W-1:0]     first_hit;
  logic                 in_header, hdr_end, is_digit, is_sep;
  logic [VALUE_W-1:0]   acc_times_ten;
  logic [SLOT_W-1:0]    limit;

  always_comb begin
    for (int i = 0; i < NUM_HDR; i++) begin
      mask_next[i] = candidate_mask[i] && (hdr_byte(CMD_W'(i), header_pos) == ch);
    end
    first_hit = '0;
    for (int i = NUM_HDR - 1; i >= 0; i--) begin
      if (mask_next[i]) begin
        first_hit = CMD_W'(i);
      end
    end
  end

  assign in_header     = (header_pos < HDR_POS_W'(HDR_LEN));
  assign hdr_end       = (header_pos == HDR_POS_W'(HDR_LEN - 1));
  assign is_digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_sep        = (ch == CH_SEMI) || (ch == CH_CLOSE);
  assign acc_times_ten = (accumulator << 3) + (accumulator << 1) + VALUE_W'(ch - CH_ZERO);
  assign limit         = (matched_command == CMD_WRITE_ALL) ? LIM_ALL : LIM_WRITE;

  // Event record and push strobe
  always_comb begin
    push             = 1'b0;
    ev.has_field     = 1'b0;
    ev.has_cmd       = 1'b0;
    ev.command       = matched_command;
    ev.slot          = slot_count;
    ev.value         = negative ? (VALUE_W'(0) - accumulator) : accumulator;
    ev.slot_overflow = (slot_count >= limit);
    if (take && ch != CH_NEWLINE && !frame_done) begin
      if (in_header) begin
        if (hdr_end && mask_next != '0 && !is_write(first_hit)) begin
          push       = 1'b1;
          ev.has_cmd = 1'b1;
          ev.command = first_hit;
        end
      end else if (in_body && is_sep) begin
        push         = 1'b1;
        ev.has_field = 1'b1;
        ev.has_cmd   = (ch == CH_CLOSE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pos      <= '0;
      candidate_mask  <= '1;
      matched_command <= '0;
      in_body         <= 1'b0;
      frame_done      <= 1'b0;
      field_chars     <= '0;
      accumulator     <= '0;
      negative        <= 1'b0;
      digits_stopped  <= 1'b0;
      slot_count      <= '0;
    end else if (take) begin
      if (ch == CH_NEWLINE) begin
        header_pos      <= '0;
        candidate_mask  <= '1;
        matched_command <= '0;
        in_body         <= 1'b0;
        frame_done      <= 1'b0;
        field_chars     <= '0;
        accumulator     <= '0;
        negative        <= 1'b0;
        digits_stopped  <= 1'b0;
        slot_count      <= '0;
      end else if (!frame_done) begin
        if (in_header) begin
          candidate_mask <= mask_next;
          header_pos     <= header_pos + 1'b1;
          if (hdr_end) begin
            if (mask_next == '0) begin
              frame_done <= 1'b1;
            end else begin
              matched_command <= first_hit;
              if (is_write(first_hit)) begin
                in_body        <= 1'b1;
                field_chars    <= '0;
                accumulator    <= '0;
                negative       <= 1'b0;
                digits_stopped <= 1'b0;
                slot_count     <= '0;
              end else begin
                frame_done <= 1'b1;
              end
            end
          end
        end else if (in_body) begin
          if (is_sep) begin
            if (slot_count != SLOT_MAX) begin
              slot_count <= slot_count + 1'b1;
            end
            field_chars    <= '0;
            accumulator    <= '0;
            negative       <= 1'b0;
            digits_stopped <= 1'b0;
            if (ch == CH_CLOSE) begin
              frame_done <= 1'b1;
              in_body    <= 1'b0;
            end
          end else if (!digits_stopped && field_chars < FC_MAX) begin
            if (ch == CH_MINUS && field_chars == '0) begin
              negative    <= 1'b1;
              field_chars <= field_chars + 1'b1;
            end else if (is_digit) begin
              accumulator <= acc_times_ten;
              field_chars <= field_chars + 1'b1;
            end else begin
              digits_stopped <= 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/cfdp_queue.sv -----
// Small event queue between front and back end, flip-flop storage.
// Depends on cfdp_pkg for event_t and depth constants.
module cfdp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cfdp_pkg::event_t push_ev,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output cfdp_pkg::event_t head
);
  import cfdp_pkg::*;

  event_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/cfdp_back.sv -----
// Back end: expands queued events into result items behind an output register.
// Depends on cfdp_pkg; a close brace event yields a field result then a command result.
module cfdp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          has_ev,
  input  cfdp_pkg::event_t              head,
  output logic                          pop,
  output logic                          valid,
  input  logic                          stall,
  output logic                          kind,
  output logic [cfdp_pkg::CMD_W-1:0]    command,
  output logic [cfdp_pkg::SLOT_W-1:0]   slot,
  output logic signed [cfdp_pkg::VALUE_W-1:0] value,
  output logic                          slot_overflow,
  output logic                          last
);
  import cfdp_pkg::*;

  logic load, phase, emit_field;

  assign load       = !valid || !stall;
  assign emit_field = head.has_field && !phase;
  // Pop once the event's final result goes out.
  assign pop        = load && has_ev && !(emit_field && head.has_cmd);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      valid <= has_ev;
      if (has_ev) begin
        phase <= emit_field && head.has_cmd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && has_ev) begin
      command <= head.command;
      if (emit_field) begin
        kind          <= KIND_FIELD;
        slot          <= head.slot;
        value         <= head.value;
        slot_overflow <= head.slot_overflow;
        last          <= 1'b0;
      end else begin
        kind          <= KIND_COMMAND;
        slot          <= '0;
        value         <= '0;
        slot_overflow <= 1'b0;
        last          <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/command_frame_decimal_parser.sv -----
// Command frame decimal parser: text bytes in, field values and command codes out.
// Channels: input ch with in_valid/in_stall; results with out_valid/out_stall and
// fields kind, command, slot, value, slot_overflow, last. A byte is taken when
// valid is high and stall is low.
// Each line starts with a five-byte header; plain commands give one command item,
// write commands give one field item per ';' or '}' and a command item on '}'.
// Newline restarts the header match at once; results already queued still drain.
// Throughput: one byte per cycle while in_stall is low. A '}' byte produces two
// results, and the four-entry event queue absorbs the extra one.
// A result is registered in the event queue after the front end decodes its byte,
// then in the output register.
// in_stall rises only while the event queue is full, which happens when the
// receiver holds out_stall. A stalled result holds its value.
// Reset (rst, synchronous) clears parser state, empties the queue and drops
// out_valid; no setup pass is needed afterwards.
module command_frame_decimal_parser #(
  parameter int WRITE_SLOTS     = 10,
  parameter int WRITE_ALL_SLOTS = 30,
  parameter int MAX_FIELD_CHARS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           ch,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 kind,
  output logic [cfdp_pkg::CMD_W-1:0]           command,
  output logic [cfdp_pkg::SLOT_W-1:0]          slot,
  output logic signed [cfdp_pkg::VALUE_W-1:0]  value,
  output logic                                 slot_overflow,
  output logic                                 last
);
  import cfdp_pkg::*;

  logic   take, push, pop, full, not_empty;
  event_t ev, head;

  assign in_stall = full;
  assign take     = in_valid && !full;

  cfdp_front #(
    .WRITE_SLOTS     (WRITE_SLOTS),
    .WRITE_ALL_SLOTS (WRITE_ALL_SLOTS),
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .ch   (ch),
    .push (push),
    .ev   (ev)
  );

  cfdp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ev   (ev),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  cfdp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .has_ev        (not_empty),
    .head          (head),
    .pop           (pop),
    .valid         (out_valid),
    .stall         (out_stall),
    .kind          (kind),
    .command       (command),
    .slot          (slot),
    .value         (value),
    .slot_overflow (slot_overflow),
    .last          (last)
  );

endmodule

// ----- rtl/core/cfdp_checker.sv -----
// Port-level checks for the command frame decimal parser, bound to the top level.
// Depends on cfdp_pkg for command and kind codes.
module cfdp_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 kind,
  input logic [cfdp_pkg::CMD_W-1:0]           command,
  input logic [cfdp_pkg::SLOT_W-1:0]          slot,
  input logic signed [cfdp_pkg::VALUE_W-1:0]  value,
  input logic                                 slot_overflow,
  input logic                                 last
);
  import cfdp_pkg::*;

  // Reset empties the output stage by the next edge.
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_cmd_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_COMMAND) |->
      (last && slot == '0 && value == '0 && !slot_overflow))
    else $error("command result carries field data");

  a_field_is_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_FIELD) |->
      (!last && (command == CMD_WRITE_1 || command == CMD_WRITE_2 ||
                 command == CMD_WRITE_3 || command == CMD_WRITE_ALL)))
    else $error("field result outside a write command");

  // Command codes stay within the header table.
  a_cmd_above_nine: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (command <= CMD_WRITE_ALL))
    else $error("command code out of range");

endmodule

bind command_frame_decimal_parser cfdp_checker u_cfdp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .kind          (kind),
  .command       (command),
  .slot          (slot),
  .value         (value),
  .slot_overflow (slot_overflow),
  .last          (last)
);
